/* sv/clew_pkg.sv */
// Shared types, constants and helpers for the character LCD expander writer.
`timescale 1ns / 1ps

package clew_pkg;

    // Input command kinds, carried in tuser
    typedef enum logic [1:0] {
        CMD_TEXT   = 2'd0,
        CMD_INSTR  = 2'd1,
        CMD_CURSOR = 2'd2,
        CMD_LIGHT  = 2'd3
    } t_cmd;

    // Configuration register indexes
    localparam logic REG_ESCAPE  = 1'b0;
    localparam logic REG_ADDRESS = 1'b1;

    localparam logic       ESCAPE_RESET  = 1'b1;
    localparam logic [6:0] ADDRESS_RESET = 7'd39;

    localparam int         QUEUE_DEPTH  = 2;
    localparam logic [7:0] LAST_COLUMN  = 8'd39;
    localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
    localparam logic [7:0] LCD_LINE_STEP = 8'h40;
    localparam logic [7:0] CHAR_SLASH    = 8'h2F;

    // One queued LCD job: pre slashes, optional main byte, post slashes,
    // or a single backlight-only write.
    typedef struct packed {
        logic       is_bl;
        logic       bl;
        logic       rs;
        logic       has_main;
        logic [7:0] main;
        logic [1:0] pre;
        logic [1:0] post;
    } t_job;

    // {hit, glyph code} for the escape letters a c e l n o s z
    function automatic logic [3:0] glyph_lookup(input logic [7:0] c);
        logic [3:0] g;
        case (c)
            8'h61:   g = 4'b1_000;
            8'h63:   g = 4'b1_001;
            8'h65:   g = 4'b1_010;
            8'h6C:   g = 4'b1_011;
            8'h6E:   g = 4'b1_100;
            8'h6F:   g = 4'b1_101;
            8'h73:   g = 4'b1_110;
            8'h7A:   g = 4'b1_111;
            default: g = 4'b0_000;
        endcase
        return g;
    endfunction

endpackage

/* sv/clew_front.sv */
// Front end: config registers, slash escape state, item classification into jobs.
`timescale 1ns / 1ps

module clew_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [0:0]           i_cfg_index,
    input  logic [6:0]           i_cfg_data,
    // input stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [23:0]          i_s_tdata,   // value[7:0], column[15:8], row[23:16]
    input  logic [1:0]           i_s_tuser,   // command[1:0]
    input  logic                 i_s_tlast,   // end_of_text
    // job queue push side
    output logic                 o_push,
    output clew_pkg::t_job       o_job,
    input  logic                 i_q_ready,
    output logic [6:0]           o_address
);

    logic       r_escape;
    logic [6:0] r_address;
    logic [1:0] r_slash_cnt;
    logic       r_bl;
    logic [1:0] n_slash_cnt;
    logic       n_bl;

    logic [7:0]      value;
    logic [7:0]      column;
    logic [7:0]      row;
    clew_pkg::t_cmd  cmd;
    logic [3:0]      glyph;
    logic [1:0]      cnt_mid;
    logic [7:0]      col_clamp;
    logic            accept;
    logic            nonempty;
    clew_pkg::t_job  job;

    assign value  = i_s_tdata[7:0];
    assign column = i_s_tdata[15:8];
    assign row    = i_s_tdata[23:16];
    assign cmd    = clew_pkg::t_cmd'(i_s_tuser);
    assign glyph  = clew_pkg::glyph_lookup(value);
    assign col_clamp = (column > clew_pkg::LAST_COLUMN) ? clew_pkg::LAST_COLUMN : column;

    always_comb begin
        job         = '0;
        cnt_mid     = r_slash_cnt;
        n_slash_cnt = r_slash_cnt;
        n_bl        = r_bl;
        unique case (cmd)
            clew_pkg::CMD_TEXT: begin
                job.rs = 1'b1;
                if (!r_escape) begin
                    job.pre      = r_slash_cnt;
                    job.has_main = 1'b1;
                    job.main     = value;
                    cnt_mid      = 2'd0;
                end else if (value == clew_pkg::CHAR_SLASH) begin
                    // third slash in a row lets the oldest one through
                    if (r_slash_cnt < 2'd2) begin
                        cnt_mid = r_slash_cnt + 2'd1;
                    end else begin
                        job.has_main = 1'b1;
                        job.main     = clew_pkg::CHAR_SLASH;
                    end
                end else if (glyph[3] && r_slash_cnt == 2'd2) begin
                    job.has_main = 1'b1;
                    job.main     = {5'd0, glyph[2:0]};
                    cnt_mid      = 2'd0;
                end else begin
                    job.pre      = r_slash_cnt;
                    job.has_main = 1'b1;
                    job.main     = value;
                    cnt_mid      = 2'd0;
                end
                if (i_s_tlast) begin
                    job.post    = cnt_mid;
                    n_slash_cnt = 2'd0;
                end else begin
                    n_slash_cnt = cnt_mid;
                end
            end
            clew_pkg::CMD_INSTR: begin
                job.has_main = 1'b1;
                job.main     = value;
            end
            clew_pkg::CMD_CURSOR: begin
                job.has_main = 1'b1;
                job.main     = clew_pkg::LCD_SET_DDRAM |
                               (col_clamp + ((row != 8'd0) ? clew_pkg::LCD_LINE_STEP : 8'd0));
            end
            clew_pkg::CMD_LIGHT: begin
                job.is_bl = 1'b1;
                n_bl      = value[0];
            end
            default: ;
        endcase
        job.bl = n_bl;
    end

    assign nonempty    = job.is_bl || job.has_main || (job.post != 2'd0);
    assign o_s_tready  = i_q_ready;
    assign accept      = i_s_tvalid && o_s_tready;
    assign o_push      = accept && nonempty;
    assign o_job       = job;
    assign o_cfg_ready = 1'b1;
    assign o_address   = r_address;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape    <= clew_pkg::ESCAPE_RESET;
            r_address   <= clew_pkg::ADDRESS_RESET;
            r_slash_cnt <= 2'd0;
            r_bl        <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    clew_pkg::REG_ESCAPE:  r_escape  <= i_cfg_data[0];
                    clew_pkg::REG_ADDRESS: r_address <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_slash_cnt <= n_slash_cnt;
                r_bl        <= n_bl;
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slash_cnt != 2'd3) else $error("slash count out of range");
    a_bl_only_on_light: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd != clew_pkg::CMD_LIGHT) |=> (r_bl == $past(r_bl)))
        else $error("backlight changed by a non-backlight item");
`endif

endmodule

/* sv/clew_queue.sv */
// Short job queue between the front end and the bus write sequencer.
`timescale 1ns / 1ps

module clew_queue #(
    parameter int DEPTH = clew_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  clew_pkg::t_job i_job,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output clew_pkg::t_job o_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    clew_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready) else $error("push into full queue");
`endif

endmodule

/* sv/clew_back.sv */
// Back end: expands each job into nibble/enable expander writes on the output stream.
`timescale 1ns / 1ps

module clew_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  clew_pkg::t_job i_q_job,
    output logic           o_pop,
    input  logic [6:0]     i_address,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [15:0]    o_m_tdata,   // bus_address[6:0], bus_byte[14:7], zero[15]
    output logic           o_m_tlast    // last
);

    logic           r_busy;
    clew_pkg::t_job r_job;
    logic [1:0]     r_idx;
    logic [1:0]     r_phase;
    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    logic [6:0]     r_out_addr;
    logic           r_out_last;

    logic [2:0] total;
    logic [7:0] cur_data;
    logic [3:0] nib;
    logic [7:0] wr_byte;
    logic       last_byte;
    logic       final_wr;
    logic       advance;

    assign total = {1'b0, r_job.pre} + {2'b0, r_job.has_main} + {1'b0, r_job.post};

    always_comb begin
        // released slashes come before and after the main byte
        if ({1'b0, r_idx} < {1'b0, r_job.pre}) begin
            cur_data = clew_pkg::CHAR_SLASH;
        end else if (r_idx == r_job.pre && r_job.has_main) begin
            cur_data = r_job.main;
        end else begin
            cur_data = clew_pkg::CHAR_SLASH;
        end
        nib = r_phase[1] ? cur_data[3:0] : cur_data[7:4];
        if (r_job.is_bl) begin
            wr_byte = {4'd0, r_job.bl, 3'd0};
        end else begin
            wr_byte = {nib, r_job.bl, ~r_phase[0], 1'b0, r_job.rs};
        end
    end

    assign last_byte = ({1'b0, r_idx} == total - 3'd1);
    assign final_wr  = r_job.is_bl || (last_byte && r_phase == 2'd3);
    assign advance   = r_busy && (!r_out_valid || i_m_tready);
    assign o_pop     = i_q_valid && (!r_busy || (advance && final_wr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_phase     <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && !advance) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= wr_byte;
                r_out_addr  <= i_address;
                r_out_last  <= final_wr;
                r_phase     <= r_phase + 2'd1;
                if (r_phase == 2'd3) begin
                    r_idx <= r_idx + 2'd1;
                end
                if (final_wr) begin
                    r_busy <= 1'b0;
                end
            end
            if (o_pop) begin
                r_busy  <= 1'b1;
                r_job   <= i_q_job;
                r_idx   <= 2'd0;
                r_phase <= 2'd0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_byte, r_out_addr};
    assign o_m_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_job_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_job.is_bl) |-> (total != 3'd0 && total <= 3'd3))
        else $error("job with bad byte count");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_job.is_bl) |-> ({1'b0, r_idx} < total))
        else $error("byte index past end of job");
`endif

endmodule

/* sv/char_lcd_expander_writer.sv */
// Top level of the character LCD writer through an I2C port expander.
`timescale 1ns / 1ps

// Takes text characters, instruction bytes, cursor moves and backlight changes on the
// slave stream and emits expander byte writes (address plus byte) on the master stream,
// HD44780 4-bit style: each LCD byte becomes four writes (high nibble with and without
// enable, then the low nibble), a backlight change becomes a single write. With escapes
// on, slash slash letter selects custom glyph 0..7; held slashes are flushed by any other
// character or by tlast. The front end accepts one item per cycle while the two-entry job
// queue has room; the back end emits one write per cycle while the master stream is ready,
// so one item takes up to twelve writes, paced by the write sequencer.
// Items that only hold back a slash produce no writes. Config writes are always ready.
module char_lcd_expander_writer #(
    parameter int QUEUE_DEPTH = clew_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // value[7:0], column[15:8], row[23:16]
    input  logic [1:0]  i_s_tuser,   // command[1:0]
    input  logic        i_s_tlast,   // end_of_text
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // bus_address[6:0], bus_byte[14:7], zero[15]
    output logic        o_m_tlast    // last
);

    logic           push;
    logic           q_ready;
    logic           q_valid;
    logic           pop;
    logic [6:0]     address;
    clew_pkg::t_job front_job;
    clew_pkg::t_job q_job;

    clew_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_push      (push),
        .o_job       (front_job),
        .i_q_ready   (q_ready),
        .o_address   (address)
    );

    clew_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    clew_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_job    (q_job),
        .o_pop      (pop),
        .i_address  (address),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

/* tb/sv/clew_checker.sv */
// Scoreboard for the character LCD expander writer: predicts expander writes and compares them.
`timescale 1ns / 1ps

module clew_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // value[7:0], column[15:8], row[23:16]
    input  logic [1:0]  i_s_tuser,   // command[1:0]
    input  logic        i_s_tlast,   // end_of_text
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // bus_address[6:0], bus_byte[14:7], zero[15]
    input  logic        i_m_tlast,   // last
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [7:0] BL_BIT     = 8'h08;
    localparam logic [7:0] EN_BIT     = 8'h04;
    localparam logic [7:0] RS_BIT     = 8'h01;
    localparam logic [7:0] NIBBLE_HI  = 8'hF0;

    typedef struct packed {
        logic [6:0] bus_address;
        logic [7:0] bus_byte;
        logic       last;
    } t_bus_write;

    t_bus_write bus_writes_due[$];

    logic       escape_on    = clew_pkg::ESCAPE_RESET;
    logic [6:0] dev_address  = clew_pkg::ADDRESS_RESET;
    logic [1:0] held_slashes = 2'd0;
    logic       backlight    = 1'b1;
    int         fail_count   = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void queue_write(input logic [7:0] b);
        t_bus_write w;
        w.bus_address = dev_address;
        w.bus_byte    = b | (backlight ? BL_BIT : 8'h00);
        w.last        = 1'b0;
        bus_writes_due.push_back(w);
    endfunction

    // one LCD byte = four expander writes, enable pulsed per nibble
    function automatic void queue_lcd_byte(input logic [7:0] data, input logic rs);
        logic [7:0] sel;
        logic [7:0] hi;
        logic [7:0] lo;
        sel = rs ? RS_BIT : 8'h00;
        hi  = data & NIBBLE_HI;
        lo  = {data[3:0], 4'h0};
        queue_write(hi | sel | EN_BIT);
        queue_write(hi | sel);
        queue_write(lo | sel | EN_BIT);
        queue_write(lo | sel);
    endfunction

    function automatic int glyph_of(input logic [7:0] c);
        int g;
        case (c)
            8'h61:   g = 0;   // a
            8'h63:   g = 1;   // c
            8'h65:   g = 2;   // e
            8'h6C:   g = 3;   // l
            8'h6E:   g = 4;   // n
            8'h6F:   g = 5;   // o
            8'h73:   g = 6;   // s
            8'h7A:   g = 7;   // z
            default: g = -1;
        endcase
        return g;
    endfunction

    function automatic void flush_slashes();
        while (held_slashes != 2'd0) begin
            queue_lcd_byte(clew_pkg::CHAR_SLASH, 1'b1);
            held_slashes = held_slashes - 2'd1;
        end
    endfunction

    function automatic void predict_item(input clew_pkg::t_cmd cmd, input logic [7:0] value,
                                         input logic [7:0] column, input logic [7:0] row,
                                         input logic eot);
        int         count_before;
        int         g;
        logic [7:0] c;
        logic [7:0] r;
        t_bus_write w;
        count_before = bus_writes_due.size();
        case (cmd)
            clew_pkg::CMD_TEXT: begin
                g = glyph_of(value);
                if (!escape_on) begin
                    flush_slashes();
                    queue_lcd_byte(value, 1'b1);
                end else if (value == clew_pkg::CHAR_SLASH) begin
                    // third slash in a row lets one go, still two held
                    if (held_slashes < 2'd2)
                        held_slashes = held_slashes + 2'd1;
                    else
                        queue_lcd_byte(clew_pkg::CHAR_SLASH, 1'b1);
                end else if (held_slashes == 2'd2 && g >= 0) begin
                    held_slashes = 2'd0;
                    queue_lcd_byte(8'(g), 1'b1);
                end else begin
                    flush_slashes();
                    queue_lcd_byte(value, 1'b1);
                end
                if (eot)
                    flush_slashes();
            end
            clew_pkg::CMD_INSTR: begin
                queue_lcd_byte(value, 1'b0);
            end
            clew_pkg::CMD_CURSOR: begin
                r = (row > 8'd1) ? 8'd1 : row;
                c = (column > clew_pkg::LAST_COLUMN) ? clew_pkg::LAST_COLUMN : column;
                queue_lcd_byte(clew_pkg::LCD_SET_DDRAM | (c + clew_pkg::LCD_LINE_STEP * r),
                               1'b0);
            end
            clew_pkg::CMD_LIGHT: begin
                backlight = value[0];
                queue_write(8'h00);
            end
        endcase
        if (bus_writes_due.size() > count_before) begin
            w      = bus_writes_due.pop_back();
            w.last = 1'b1;
            bus_writes_due.push_back(w);
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_bus_write w;
        if (!i_rst_n) begin
            escape_on    = clew_pkg::ESCAPE_RESET;
            dev_address  = clew_pkg::ADDRESS_RESET;
            held_slashes = 2'd0;
            backlight    = 1'b1;
            bus_writes_due.delete();
        end else begin
            // outputs first: a write never stems from an item taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                if (bus_writes_due.size() == 0) begin
                    $error("unexpected bus write: tdata %h tlast %b", i_m_tdata, i_m_tlast);
                    fail_count++;
                end else begin
                    w = bus_writes_due.pop_front();
                    check_field("bus_address", {1'b0, w.bus_address}, {1'b0, i_m_tdata[6:0]});
                    check_field("bus_byte", w.bus_byte, i_m_tdata[14:7]);
                    check_field("last", {7'd0, w.last}, {7'd0, i_m_tlast});
                    check_field("pad", 8'd0, {7'd0, i_m_tdata[15]});
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == clew_pkg::REG_ESCAPE)
                    escape_on = i_cfg_data[0];
                else
                    dev_address = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready)
                predict_item(clew_pkg::t_cmd'(i_s_tuser), i_s_tdata[7:0], i_s_tdata[15:8],
                             i_s_tdata[23:16], i_s_tlast);
        end
        o_fail_count <= fail_count;
        o_pending    <= bus_writes_due.size();
    end

endmodule

/* tb/sv/tb_char_lcd_expander_writer.sv */
// Testbench top for the character LCD expander writer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_char_lcd_expander_writer;

    localparam int         SETTLE_CYCLES = 30;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         HOLD_CYCLES   = 80;
    localparam logic [1:0] MODE_RECV_SLOW = 2'd0;   // sender idles 23%, receiver 79%
    localparam logic [1:0] MODE_SEND_SLOW = 2'd1;   // sender idles 79%, receiver 23%
    localparam logic [1:0] MODE_NONE      = 2'd2;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = clew_pkg::REG_ESCAPE;
    logic [6:0]  i_cfg_data  = 7'd0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata   = 24'd0;
    logic [1:0]  i_s_tuser   = clew_pkg::CMD_TEXT;
    logic        i_s_tlast   = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [15:0] o_m_tdata;
    logic        o_m_tlast;

    int          fail_count;
    int          pending;
    logic [1:0]  idle_mode    = MODE_RECV_SLOW;
    int          hold_left    = 0;
    logic        hold_done    = 1'b0;
    int          stall_cycles = 0;
    logic [7:0]  glyph_letters [8] = '{8'h61, 8'h63, 8'h65, 8'h6C, 8'h6E, 8'h6F, 8'h73, 8'h7A};

    always #5 i_clk = ~i_clk;

    char_lcd_expander_writer u_dut (.*);

    clew_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // output side: random backpressure plus one long hold once nothing idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (idle_mode == MODE_NONE && !hold_done && o_m_tvalid) begin
            i_m_tready <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_done  <= 1'b1;
        end else begin
            i_m_tready <= $urandom_range(99) >= ((idle_mode == MODE_RECV_SLOW) ? 79 :
                                                 (idle_mode == MODE_SEND_SLOW) ? 23 : 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_item(input clew_pkg::t_cmd cmd, input logic [7:0] value,
                             input logic [7:0] column, input logic [7:0] row,
                             input logic eot);
        while ($urandom_range(99) < ((idle_mode == MODE_RECV_SLOW) ? 23 :
                                     (idle_mode == MODE_SEND_SLOW) ? 79 : 0)) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {row, column, value};
        i_s_tlast  <= eot;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // both registers in one go; valid stays high between them
    task automatic set_config(input logic esc, input logic [6:0] addr);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= clew_pkg::REG_ESCAPE;
        i_cfg_data  <= {6'd0, esc};
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= clew_pkg::REG_ADDRESS;
        i_cfg_data  <= addr;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random(input int count);
        int         sent;
        int         pick;
        int         nslash;
        logic [7:0] ch;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                // escape run, now and then a slash short or over, or split by an instruction
                nslash = ($urandom_range(3) == 0) ? $urandom_range(3) : 2;
                repeat (nslash)
                    send_item(clew_pkg::CMD_TEXT, clew_pkg::CHAR_SLASH, 8'($urandom),
                              8'($urandom), $urandom_range(19) == 0);
                if ($urandom_range(6) == 0) begin
                    send_item(clew_pkg::CMD_INSTR, 8'($urandom), 8'($urandom), 8'($urandom),
                              1'($urandom_range(1)));
                    sent++;
                end
                ch = ($urandom_range(3) != 0) ? glyph_letters[3'($urandom_range(7))]
                                              : 8'($urandom_range(255));
                send_item(clew_pkg::CMD_TEXT, ch, 8'($urandom), 8'($urandom),
                          $urandom_range(4) == 0);
                sent += nslash + 1;
            end else if (pick < 70) begin
                pick = $urandom_range(99);
                ch = (pick < 25) ? clew_pkg::CHAR_SLASH :
                     (pick < 50) ? glyph_letters[3'($urandom_range(7))] :
                                   8'($urandom_range(255));
                send_item(clew_pkg::CMD_TEXT, ch, 8'($urandom), 8'($urandom),
                          $urandom_range(6) == 0);
                sent++;
            end else if (pick < 82) begin
                send_item(clew_pkg::CMD_INSTR, 8'($urandom), 8'($urandom), 8'($urandom),
                          1'($urandom_range(1)));
                sent++;
            end else if (pick < 93) begin
                send_item(clew_pkg::CMD_CURSOR, 8'($urandom),
                          ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(45)),
                          ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(2)),
                          1'($urandom_range(1)));
                sent++;
            end else begin
                send_item(clew_pkg::CMD_LIGHT, 8'($urandom), 8'($urandom), 8'($urandom),
                          1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items at reset configuration
        send_item(clew_pkg::CMD_TEXT,   8'h48, 8'h00, 8'h00, 1'b0);
        send_item(clew_pkg::CMD_INSTR,  8'h00, 8'h00, 8'h00, 1'b0);
        send_item(clew_pkg::CMD_INSTR,  8'hFF, 8'h00, 8'h00, 1'b1);
        send_item(clew_pkg::CMD_CURSOR, 8'h00, 8'd0,  8'd0,  1'b0);
        send_item(clew_pkg::CMD_CURSOR, 8'hFF, 8'd255, 8'd255, 1'b0);
        send_item(clew_pkg::CMD_CURSOR, 8'h00, 8'd39, 8'd1,  1'b0);
        send_item(clew_pkg::CMD_CURSOR, 8'h00, 8'd40, 8'd2,  1'b0);
        send_item(clew_pkg::CMD_LIGHT,  8'hFE, 8'h00, 8'h00, 1'b0);   // backlight off
        send_item(clew_pkg::CMD_TEXT,   8'hFF, 8'h00, 8'h00, 1'b0);
        send_item(clew_pkg::CMD_LIGHT,  8'h01, 8'h00, 8'h00, 1'b0);
        repeat (2) send_item(clew_pkg::CMD_TEXT, clew_pkg::CHAR_SLASH, 8'h00, 8'h00, 1'b0);
        send_item(clew_pkg::CMD_TEXT,   8'h61, 8'h00, 8'h00, 1'b0);   // glyph 0
        repeat (3) send_item(clew_pkg::CMD_TEXT, clew_pkg::CHAR_SLASH, 8'h00, 8'h00, 1'b0);
        send_item(clew_pkg::CMD_TEXT,   8'h7A, 8'h00, 8'h00, 1'b0);   // glyph 7
        repeat (2) send_item(clew_pkg::CMD_TEXT, clew_pkg::CHAR_SLASH, 8'h00, 8'h00, 1'b0);
        send_item(clew_pkg::CMD_TEXT,   8'h62, 8'h00, 8'h00, 1'b0);   // not a glyph letter
        send_item(clew_pkg::CMD_TEXT,   clew_pkg::CHAR_SLASH, 8'h00, 8'h00, 1'b0);
        send_item(clew_pkg::CMD_INSTR,  8'h01, 8'h00, 8'h00, 1'b0);   // held slash survives
        send_item(clew_pkg::CMD_TEXT,   clew_pkg::CHAR_SLASH, 8'h00, 8'h00, 1'b0);
        send_item(clew_pkg::CMD_TEXT,   8'h6F, 8'h00, 8'h00, 1'b0);   // glyph 5
        repeat (2) send_item(clew_pkg::CMD_TEXT, clew_pkg::CHAR_SLASH, 8'h00, 8'h00, 1'b0);
        send_item(clew_pkg::CMD_TEXT,   clew_pkg::CHAR_SLASH, 8'h00, 8'h00, 1'b1); // twelve writes
        send_item(clew_pkg::CMD_TEXT,   8'h00, 8'h00, 8'h00, 1'b1);
        wait_drained();

        set_config(1'b1, 7'd127);
        send_random(10);
        wait_drained();
        send_random(10);
        wait_drained();

        idle_mode <= MODE_SEND_SLOW;
        set_config(1'b0, 7'd0);
        send_random(26);
        wait_drained();

        idle_mode <= MODE_NONE;
        set_config(1'b1, 7'($urandom_range(1, 126)));
        send_random(26);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
